// ===== rtl/uttip_pkg.sv =====
// Shared constants, types and the character classifier for the text-to-integer parser.
// No dependencies; used by unsigned_text_to_integer_parser.
package uttip_pkg;

    localparam int CHAR_W               = 8;
    localparam int BASE_W               = 6;
    localparam int DIGIT_W              = 6;
    localparam int VALUE_W              = 32;
    localparam int OFFSET_W             = 13;
    localparam int DEFAULT_MAX_STRING_LEN = 4096;

    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] BASE_INVALID = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET   = BASE_DEC;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd10;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    function automatic t_digit digit_value(input logic [CHAR_W-1:0] c);
        t_digit d;
        logic [CHAR_W-1:0] v;
        d = '0;
        v = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
            d.ok = 1'b1;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            v = c - CHAR_UP_A + LETTER_BIAS;
            d.ok = 1'b1;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            v = c - CHAR_LO_A + LETTER_BIAS;
            d.ok = 1'b1;
        end
        d.val = v[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

// ===== rtl/unsigned_text_to_integer_parser.sv =====
// Streaming unsigned text-to-integer parser, one character beat per cycle when not stalled.
// Depends on uttip_pkg (constants, t_digit, digit_value).
//
// Channel   Dir  Signals                       Contents
// s         in   i_s_tvalid/o_s_tready         tdata[7:0] char_code, tlast last_char
// m         out  o_m_tvalid/i_m_tready         tdata[31:0] parsed_value,
//                                              [44:32] end_offset, [45] any_digits
// cfg       in   i_cfg_valid/o_cfg_ready       data[5:0] number_base
//
// Each character waits in the input register while the parse logic
// (a 32x6 multiply-add with saturation) updates the state; the result register
// loads as a last beat is parsed. A new beat can be accepted every cycle unless stalled.
// Synchronous active-low reset clears the parse state and sets number_base to 10.
// A stalled result holds the parse stage only while a last beat waits behind it.
module unsigned_text_to_integer_parser #(
    parameter int MAX_STRING_LEN = uttip_pkg::DEFAULT_MAX_STRING_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [uttip_pkg::CHAR_W-1:0]  i_s_tdata,   // [7:0] char_code
    input  logic                          i_s_tlast,   // last_char
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [47:0]                   o_m_tdata,   // parsed_value, end_offset, any_digits
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [uttip_pkg::BASE_W-1:0]  i_cfg_data   // number_base
);

    localparam int POS_W = $clog2(MAX_STRING_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN);
    localparam int PROD_W = uttip_pkg::VALUE_W + uttip_pkg::BASE_W;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGN,
        PH_START,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    logic                            r_in_valid;
    logic [uttip_pkg::CHAR_W-1:0]    r_code;
    logic                            r_last;
    logic [uttip_pkg::BASE_W-1:0]    r_number_base;

    t_phase                          r_phase, n_phase;
    logic [uttip_pkg::VALUE_W-1:0]   r_acc, n_acc;
    logic                            r_minus, n_minus;
    logic [uttip_pkg::BASE_W-1:0]    r_base, n_base;
    logic                            r_pz, n_pz;
    logic [POS_W-1:0]                r_pos, n_pos;
    logic [POS_W-1:0]                r_dend, n_dend;
    logic                            r_dseen, n_dseen;

    logic                            r_out_valid;
    logic [uttip_pkg::VALUE_W-1:0]   r_out_value;
    logic [uttip_pkg::OFFSET_W-1:0]  r_out_offset;
    logic                            r_out_any;

    logic                            advance;
    logic                            proc;
    logic [uttip_pkg::CHAR_W-1:0]    code;
    uttip_pkg::t_digit               dig;
    logic [PROD_W-1:0]               prod;
    logic                            used;
    logic [uttip_pkg::VALUE_W-1:0]   res_value;
    logic [POS_W-1:0]                res_end;
    logic [POS_W+uttip_pkg::OFFSET_W-1:0] res_end_wide;

    assign advance     = !r_out_valid || i_m_tready;
    assign proc        = r_in_valid && (advance || !r_last);
    assign o_s_tready  = !r_in_valid || proc;
    assign o_cfg_ready = 1'b1;

    assign code = (r_pos < POS_MAX) ? r_code : uttip_pkg::CHAR_NUL;
    assign dig  = uttip_pkg::digit_value(code);
    assign prod = PROD_W'(r_acc) * PROD_W'(r_base) + PROD_W'(dig.val);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_base  = r_base;
        n_pz    = r_pz;
        n_dend  = r_dend;
        n_dseen = r_dseen;
        used    = 1'b0;

        if (r_pos == '0) begin
            n_base = r_number_base;
            if (n_base == uttip_pkg::BASE_INVALID || n_base > uttip_pkg::BASE_MAX) begin
                n_phase = PH_STOP;
            end
        end

        if (n_phase == PH_SPACE) begin
            if (code == uttip_pkg::CHAR_SPACE ||
                (code >= uttip_pkg::CHAR_TAB && code <= uttip_pkg::CHAR_CR)) begin
                used = 1'b1;
            end else begin
                n_phase = PH_SIGN;
            end
        end

        if (!used && n_phase == PH_SIGN) begin
            n_phase = PH_START;
            if (code == uttip_pkg::CHAR_MINUS) begin
                n_minus = 1'b1;
                used    = 1'b1;
            end else if (code == uttip_pkg::CHAR_PLUS) begin
                used = 1'b1;
            end
        end

        if (!used && n_phase == PH_START) begin
            if (r_pz) begin
                n_pz = 1'b0;
                if (code == uttip_pkg::CHAR_LO_X || code == uttip_pkg::CHAR_UP_X) begin
                    n_base  = uttip_pkg::BASE_HEX;
                    n_phase = PH_DIGITS;
                    used    = 1'b1;
                end else begin
                    if (n_base == uttip_pkg::BASE_AUTO) begin
                        n_base = uttip_pkg::BASE_OCT;
                    end
                    n_phase = PH_DIGITS;
                    n_dseen = 1'b1;
                    n_dend  = r_pos;
                end
            end else if ((n_base == uttip_pkg::BASE_AUTO || n_base == uttip_pkg::BASE_HEX) &&
                         code == uttip_pkg::CHAR_ZERO) begin
                n_pz = 1'b1;
                used = 1'b1;
            end else begin
                if (n_base == uttip_pkg::BASE_AUTO) begin
                    n_base = (dig.ok && dig.val == '0) ? uttip_pkg::BASE_OCT
                                                       : uttip_pkg::BASE_DEC;
                end
                n_phase = PH_DIGITS;
            end
        end

        if (!used && n_phase == PH_DIGITS) begin
            if (!dig.ok || dig.val >= n_base) begin
                n_phase = PH_STOP;
            end else begin
                if (r_phase == PH_DIGITS) begin
                    n_acc = (prod[PROD_W-1:uttip_pkg::VALUE_W] != '0) ? '1
                                                                      : prod[uttip_pkg::VALUE_W-1:0];
                end else begin
                    n_acc = uttip_pkg::VALUE_W'(dig.val);
                end
                n_dseen = 1'b1;
                n_dend  = r_pos + POS_W'(1);
            end
        end

        n_pos = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;

        if (r_last && n_phase == PH_START && n_pz) begin
            n_dseen = 1'b1;
            n_dend  = n_pos;
        end

        res_value    = n_minus ? (~n_acc + uttip_pkg::VALUE_W'(1)) : n_acc;
        res_end      = n_dseen ? n_dend : '0;
        res_end_wide = {{uttip_pkg::OFFSET_W{1'b0}}, res_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_number_base <= uttip_pkg::BASE_RESET;
            r_phase       <= PH_SPACE;
            r_acc         <= '0;
            r_minus       <= 1'b0;
            r_base        <= '0;
            r_pz          <= 1'b0;
            r_pos         <= '0;
            r_dend        <= '0;
            r_dseen       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_number_base <= i_cfg_data;
            end

            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            if (proc) begin
                if (r_last) begin
                    r_phase <= PH_SPACE;
                    r_acc   <= '0;
                    r_minus <= 1'b0;
                    r_base  <= '0;
                    r_pz    <= 1'b0;
                    r_pos   <= '0;
                    r_dend  <= '0;
                    r_dseen <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_acc   <= n_acc;
                    r_minus <= n_minus;
                    r_base  <= n_base;
                    r_pz    <= n_pz;
                    r_pos   <= n_pos;
                    r_dend  <= n_dend;
                    r_dseen <= n_dseen;
                end
            end

            if (proc && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_code <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (proc && r_last) begin
            r_out_value  <= res_value;
            r_out_offset <= res_end_wide[uttip_pkg::OFFSET_W-1:0];
            r_out_any    <= n_dseen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_any, r_out_offset, r_out_value};

endmodule

// ===== tb/unsigned_text_to_integer_parser_tb.sv =====
// Self-checking testbench for unsigned_text_to_integer_parser: character beats in,
// parsed numbers out, compared against a cycle-free predictor of the parse.
// Depends on uttip_pkg and the parser RTL.
module unsigned_text_to_integer_parser_tb;
    import uttip_pkg::*;

    localparam int MAX_LEN    = DEFAULT_MAX_STRING_LEN;
    localparam int OFFSET_LSB = VALUE_W;
    localparam int DIGITS_BIT = VALUE_W + OFFSET_W;
    localparam int RANDOM_CHARS = 1000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        SCAN_SPACE, SCAN_SIGN, SCAN_PREFIX, SCAN_DIGITS, SCAN_STOP
    } t_scan_phase;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] code;
    } t_char;

    typedef struct packed {
        logic                digits;
        logic [OFFSET_W-1:0] offset;
        logic [VALUE_W-1:0]  value;
    } t_number;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [CHAR_W-1:0]   i_s_tdata = '0;
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [47:0]         o_m_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [BASE_W-1:0]   i_cfg_data = '0;

    t_char               pending_chars[$];
    t_number             expected_numbers[$];
    logic [CHAR_W-1:0]   word[$];
    int                  sent_chars;
    int                  mismatch_count = 0;

    logic [BASE_W-1:0]   radix_reg = BASE_RESET;
    t_scan_phase         scan_phase;
    logic [VALUE_W-1:0]  scan_value;
    logic                scan_minus;
    logic [BASE_W-1:0]   scan_base;
    logic                scan_zero_wait;
    logic [OFFSET_W-1:0] scan_pos;
    logic [OFFSET_W-1:0] scan_digit_end;
    logic                scan_digit_seen;

    t_char               beat;
    int                  burst_left = 0;
    int                  gap_left = 0;
    t_rx_mode            rx_mode = RX_OPEN;
    int                  rx_left = 0;
    logic [7:0]          rx_tick = '0;
    logic                got_number;
    t_number             predicted;
    t_number             want;

    unsigned_text_to_integer_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic int char_digit(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO);
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
            return int'(c) - int'(CHAR_UP_A) + int'(LETTER_BIAS);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
            return int'(c) - int'(CHAR_LO_A) + int'(LETTER_BIAS);
        return -1;
    endfunction

    task automatic clear_scan();
        scan_phase = SCAN_SPACE;
        scan_value = '0;
        scan_minus = 1'b0;
        scan_base = BASE_AUTO;
        scan_zero_wait = 1'b0;
        scan_pos = '0;
        scan_digit_end = '0;
        scan_digit_seen = 1'b0;
    endtask

    task automatic start_digits(input int first);
        if (scan_base == BASE_AUTO) scan_base = (first == 0) ? BASE_OCT : BASE_DEC;
        scan_phase = SCAN_DIGITS;
    endtask

    task automatic accum_digit(input int d, input logic [OFFSET_W-1:0] end_pos);
        logic [63:0] nxt;
        if (d < 0 || d >= int'(scan_base)) begin
            scan_phase = SCAN_STOP;
            return;
        end
        nxt = 64'(scan_value) * 64'(scan_base) + 64'(d);
        scan_value = (nxt > 64'hFFFF_FFFF) ? '1 : nxt[VALUE_W-1:0];
        scan_digit_seen = 1'b1;
        scan_digit_end = end_pos;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] code_in, input logic last,
                              output logic emit, output t_number num);
        logic [CHAR_W-1:0]   code;
        logic [OFFSET_W-1:0] pos;
        logic                used;
        code = code_in;
        pos = scan_pos;
        used = 1'b0;
        emit = 1'b0;
        num = '0;
        if (pos == 0) begin
            scan_base = radix_reg;
            if (scan_base == BASE_INVALID || scan_base > BASE_MAX) scan_phase = SCAN_STOP;
        end
        if (pos >= MAX_LEN) code = CHAR_NUL;
        if (scan_phase == SCAN_SPACE) begin
            if (code == CHAR_SPACE || (code >= CHAR_TAB && code <= CHAR_CR)) used = 1'b1;
            else scan_phase = SCAN_SIGN;
        end
        if (!used && scan_phase == SCAN_SIGN) begin
            scan_phase = SCAN_PREFIX;
            if (code == CHAR_MINUS) begin
                scan_minus = 1'b1;
                used = 1'b1;
            end else if (code == CHAR_PLUS) begin
                used = 1'b1;
            end
        end
        if (!used && scan_phase == SCAN_PREFIX) begin
            if (scan_zero_wait) begin
                scan_zero_wait = 1'b0;
                if (code == CHAR_LO_X || code == CHAR_UP_X) begin
                    scan_base = BASE_HEX;
                    scan_phase = SCAN_DIGITS;
                    used = 1'b1;
                end else begin
                    start_digits(0);
                    accum_digit(0, pos);
                end
            end else if ((scan_base == BASE_AUTO || scan_base == BASE_HEX) &&
                         code == CHAR_ZERO) begin
                scan_zero_wait = 1'b1;
                used = 1'b1;
            end else begin
                start_digits(char_digit(code));
            end
        end
        if (!used && scan_phase == SCAN_DIGITS) accum_digit(char_digit(code), pos + 13'd1);
        if (scan_pos < MAX_LEN) scan_pos++;
        if (last) begin
            if (scan_phase == SCAN_PREFIX && scan_zero_wait) begin
                scan_zero_wait = 1'b0;
                start_digits(0);
                accum_digit(0, scan_pos);
            end
            num.value = scan_minus ? (32'd0 - scan_value) : scan_value;
            num.offset = scan_digit_seen ? scan_digit_end : '0;
            num.digits = scan_digit_seen;
            emit = 1'b1;
            clear_scan();
        end
    endtask

    // Hand the assembled string (a lone NUL if empty) to the driver, tagging its final character.
    task automatic flush_word();
        t_char c;
        if (word.size() == 0) word.push_back(CHAR_NUL);
        foreach (word[i]) begin
            c.code = word[i];
            c.last = (i == word.size() - 1);
            pending_chars.push_back(c);
        end
        sent_chars += word.size();
        word.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) word.push_back(s[i]);
        flush_word();
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input int v);
        if (v < int'(LETTER_BIAS)) return CHAR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'(v - int'(LETTER_BIAS));
    endfunction

    function automatic logic [CHAR_W-1:0] space_char();
        if ($urandom_range(0, 5) == 0) return CHAR_SPACE;
        return 8'($urandom_range(CHAR_TAB, CHAR_CR));
    endfunction

    task automatic make_string(input logic [BASE_W-1:0] radix);
        int kind;
        int ndig;
        int eb;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            repeat ($urandom_range(1, 6)) word.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) word.push_back(space_char());
            case ($urandom_range(0, 3))
                0: word.push_back(CHAR_MINUS);
                1: word.push_back(CHAR_PLUS);
                default: ;
            endcase
            eb = (radix >= 2 && radix <= BASE_MAX) ? int'(radix) : int'(BASE_DEC);
            if ((radix == BASE_AUTO || radix == BASE_HEX) && $urandom_range(0, 2) == 0) begin
                word.push_back(CHAR_ZERO);
                word.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
                eb = int'(BASE_HEX);
            end else if (radix == BASE_AUTO && $urandom_range(0, 2) == 0) begin
                word.push_back(CHAR_ZERO);
                eb = int'(BASE_OCT);
            end
            if ($urandom_range(0, 9) == 0) ndig = 0;
            else if ($urandom_range(0, 5) == 0) ndig = $urandom_range(9, 14);
            else ndig = $urandom_range(1, 8);
            repeat (ndig) word.push_back(digit_char($urandom_range(0, eb - 1)));
            if (kind < 6)
                word.insert($urandom_range(0, word.size()), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) word.push_back(8'($urandom_range(0, 255)));
        end
        flush_word();
    endtask

    // Hold until every beat is taken and every number has come back.
    task automatic drain();
        while (pending_chars.size() != 0 || i_s_tvalid || expected_numbers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= b;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        logic [BASE_W-1:0] edges[6];
        edges = '{BASE_AUTO, 6'd2, BASE_OCT, BASE_DEC, BASE_HEX, BASE_MAX};
        r = $urandom_range(0, 15);
        if (r == 0) return $urandom_range(0, 1) ? BASE_INVALID : 6'($urandom_range(37, 63));
        if (r < 5) return edges[$urandom_range(0, 5)];
        r = $urandom_range(0, 36);
        return (r == int'(BASE_INVALID)) ? BASE_AUTO : 6'(r);
    endfunction

    // Sender: bursts of beats separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0 || pending_chars.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_s_tvalid <= 1'b0;
            end else begin
                beat = pending_chars.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= beat.code;
                i_s_tlast <= beat.last;
                if (burst_left == 0) burst_left = $urandom_range(1, 32);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // Receiver: backpressure mode is picked anew at random among open, coin, sparse and pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:    i_m_tready <= 1'b1;
                RX_COIN:    i_m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  i_m_tready <= ($urandom_range(0, 4) == 0);
                RX_PATTERN: i_m_tready <= (rx_tick[1:0] != 2'b11);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) radix_reg = i_cfg_data;
            if (i_s_tvalid && o_s_tready) begin
                parse_char(i_s_tdata, i_s_tlast, got_number, predicted);
                if (got_number) expected_numbers.push_back(predicted);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch("unexpected number", o_m_tdata[VALUE_W-1:0], '0);
                end else begin
                    want = expected_numbers.pop_front();
                    if (o_m_tdata[VALUE_W-1:0] !== want.value)
                        report_mismatch("parsed_value", o_m_tdata[VALUE_W-1:0], want.value);
                    if (o_m_tdata[DIGITS_BIT-1:OFFSET_LSB] !== want.offset)
                        report_mismatch("end_offset", 32'(o_m_tdata[DIGITS_BIT-1:OFFSET_LSB]),
                                        32'(want.offset));
                    if (o_m_tdata[DIGITS_BIT] !== want.digits)
                        report_mismatch("any_digits", 32'(o_m_tdata[DIGITS_BIT]),
                                        32'(want.digits));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        clear_scan();
        sent_chars = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        word = '{CHAR_TAB, 8'h0B, CHAR_CR, CHAR_SPACE, CHAR_PLUS, CHAR_NINE, 8'hFF, CHAR_NUL};
        flush_word();
        word.push_back(CHAR_NUL);
        flush_word();
        send_text("-7");
        write_base(BASE_MAX);
        send_text("-zzzzzzzz");
        write_base(BASE_HEX);
        send_text("0x");
        send_text("0");
        send_text("0XfF");
        write_base(BASE_AUTO);
        send_text("017");
        send_text("0x1A");
        send_text("9");
        write_base(BASE_INVALID);
        send_text("5");
        write_base(6'd63);
        send_text("5");

        sent_chars = 0;
        while (sent_chars < RANDOM_CHARS) begin
            write_base(pick_base());
            repeat ($urandom_range(3, 10)) make_string(radix_reg);
        end

        write_base(BASE_DEC);
        send_text("-12");

        drain();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
